// ----- sv/assert_macros.svh -----
// Assertion macros used by the interpreter core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define BFI_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high
`define BFI_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/bfi_pkg.sv -----
// Types and constants of the interpreter core.
`default_nettype none

package bfi_pkg;

  // Default store depths (powers of two)
  localparam int DATA_DEPTH_DEF = 32768;
  localparam int PROG_DEPTH_DEF = 4096;

  localparam int PROG_ADDR_W = 12;

  // Instruction characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_RIGHT = 8'h3E;
  localparam logic [7:0] CH_LEFT  = 8'h3C;
  localparam logic [7:0] CH_INC   = 8'h2B;
  localparam logic [7:0] CH_DEC   = 8'h2D;
  localparam logic [7:0] CH_OUT   = 8'h2E;
  localparam logic [7:0] CH_IN    = 8'h2C;
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;

  // Command function codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_EXEC  = 1'b1;

  typedef struct packed {
    logic                   func;
    logic [PROG_ADDR_W-1:0] prog_addr;
    logic [7:0]             prog_char;
    logic [7:0]             in_byte;
  } cmd_t;

  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic       in_taken;
    logic       halted;
    logic       bracket_error;
  } res_t;

endpackage

`default_nettype wire

// ----- sv/brainfuck_interpreter_core.sv -----
// Brainfuck interpreter core: program and data stores with a control sequencer.
//
//   port group  | dir | word   | accepted when
//   ------------+-----+--------+-------------------------
//   cmd         | in  | cmd_t  | cmd_valid && !cmd_stall
//   res         | out | res_t  | res_valid && !res_stall
//
// A program write is stored in the cycle it is accepted; a plain instruction
// first reads the program and data stores, then executes and writes back. A
// bracket scan walks one program character at a time, set by the single
// program store read port. After reset a clearing pass zeroes both stores;
// cmd_stall stays high during it. The result register lets a word wait under
// res_stall while the next command is accepted.
`default_nettype none
`include "assert_macros.svh"

module brainfuck_interpreter_core #(
  parameter int DATA_DEPTH = bfi_pkg::DATA_DEPTH_DEF,
  parameter int PROG_DEPTH = bfi_pkg::PROG_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  bfi_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_stall,
  output bfi_pkg::res_t res
);
  import bfi_pkg::*;

  localparam int PAW  = $clog2(PROG_DEPTH);
  localparam int DAW  = $clog2(DATA_DEPTH);
  localparam int CW   = (PAW > DAW) ? PAW : DAW;
  localparam int MAXD = (PROG_DEPTH > DATA_DEPTH) ? PROG_DEPTH : DATA_DEPTH;
  localparam int AXW  = (PAW > PROG_ADDR_W) ? PAW : PROG_ADDR_W;
  localparam logic [PAW-1:0] PC_LAST = PAW'(PROG_DEPTH - 1);
  localparam logic [DAW-1:0] DP_LAST = DAW'(DATA_DEPTH - 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_EXEC, S_SCAN_F, S_SCAN_B, S_RESP
  } state_t;

  state_t state;

  // Stores
  logic [7:0] prog_mem [PROG_DEPTH];
  logic [7:0] data_mem [DATA_DEPTH];

  logic [PAW-1:0] prog_raddr, prog_waddr;
  logic [7:0]     prog_rd, prog_wdata;
  logic           prog_we;
  logic [DAW-1:0] data_waddr;
  logic [7:0]     data_rd, data_wdata;
  logic           data_we;

  // Architectural and control registers
  logic [PAW-1:0] pc, scan;
  logic [DAW-1:0] dp;
  logic [PAW:0]   depth;
  logic [CW-1:0]  clr;
  logic [7:0]     in_hold;
  res_t           pend;

  logic           cmd_acc, out_free, done, scan_hit, res_load;
  res_t           done_res;
  logic [AXW-1:0] cmd_addr;
  logic [PAW-1:0] pc_inc, scan_inc;
  logic [DAW-1:0] dp_inc, dp_dec;
  logic           clr_in_prog, clr_in_data;

  assign cmd_stall = (state != S_IDLE);
  assign cmd_acc   = cmd_valid && !cmd_stall;
  assign out_free  = !res_valid || !res_stall;
  assign res_load  = out_free && (done || (state == S_RESP));
  assign cmd_addr  = AXW'(cmd.prog_addr);

  assign pc_inc   = (pc == PC_LAST) ? '0 : pc + 1'b1;
  assign scan_inc = (scan == PC_LAST) ? '0 : scan + 1'b1;
  assign dp_inc   = (dp == DP_LAST) ? '0 : dp + 1'b1;
  assign dp_dec   = (dp == '0) ? DP_LAST : dp - 1'b1;

  assign clr_in_prog = ({1'b0, clr} < (CW + 1)'(PROG_DEPTH));
  assign clr_in_data = ({1'b0, clr} < (CW + 1)'(DATA_DEPTH));

  // Program store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (prog_we) begin
      prog_mem[prog_waddr] <= prog_wdata;
    end
    prog_rd <= prog_mem[prog_raddr];
  end

  // Data store: read at the pointer, write back the modified cell
  always_ff @(posedge clk) begin
    if (data_we) begin
      data_mem[data_waddr] <= data_wdata;
    end
    data_rd <= data_mem[dp];
  end

  // Store access, completion and result word per state
  always_comb begin
    done       = 1'b0;
    scan_hit   = 1'b0;
    done_res   = '0;
    prog_we    = 1'b0;
    prog_waddr = cmd_addr[PAW-1:0];
    prog_wdata = cmd.prog_char;
    prog_raddr = pc;
    data_we    = 1'b0;
    data_waddr = dp;
    data_wdata = data_rd;
    case (state)
      S_CLEAR: begin
        prog_we    = clr_in_prog;
        prog_waddr = clr[PAW-1:0];
        prog_wdata = '0;
        data_we    = clr_in_data;
        data_waddr = clr[DAW-1:0];
        data_wdata = '0;
      end
      S_IDLE: begin
        if (cmd_acc && (cmd.func == FUNC_WRITE)) begin
          prog_we = 1'b1;
          done    = 1'b1;
        end
      end
      S_EXEC: begin
        // first scan read goes out here
        prog_raddr = (prog_rd == CH_CLOSE) ? pc - 1'b1 : pc + 1'b1;
        case (prog_rd)
          CH_NUL: begin
            done              = 1'b1;
            done_res.halted   = 1'b1;
          end
          CH_OPEN: begin
            if (data_rd != 8'd0) begin
              done = 1'b1;
            end else if (pc == PC_LAST) begin
              done                   = 1'b1;
              done_res.bracket_error = 1'b1;
            end
          end
          CH_CLOSE: begin
            if (pc == '0) begin
              done                   = 1'b1;
              done_res.bracket_error = 1'b1;
            end
          end
          CH_INC: begin
            data_we    = 1'b1;
            data_wdata = data_rd + 8'd1;
            done       = 1'b1;
          end
          CH_DEC: begin
            data_we    = 1'b1;
            data_wdata = data_rd - 8'd1;
            done       = 1'b1;
          end
          CH_OUT: begin
            done               = 1'b1;
            done_res.out_valid = 1'b1;
            done_res.out_byte  = data_rd;
          end
          CH_IN: begin
            data_we           = 1'b1;
            data_wdata        = in_hold;
            done              = 1'b1;
            done_res.in_taken = 1'b1;
          end
          default: begin
            done = 1'b1;
          end
        endcase
      end
      S_SCAN_F: begin
        prog_raddr = scan + 1'b1;
        if (prog_rd == CH_NUL) begin
          done                   = 1'b1;
          done_res.bracket_error = 1'b1;
        end else if ((prog_rd == CH_CLOSE) && (depth == (PAW + 1)'(1))) begin
          done     = 1'b1;
          scan_hit = 1'b1;
        end else if (scan == PC_LAST) begin
          done                   = 1'b1;
          done_res.bracket_error = 1'b1;
        end
      end
      S_SCAN_B: begin
        prog_raddr = scan - 1'b1;
        if ((prog_rd == CH_OPEN) && (depth == (PAW + 1)'(1))) begin
          done     = 1'b1;
          scan_hit = 1'b1;
        end else if (scan == '0) begin
          done                   = 1'b1;
          done_res.bracket_error = 1'b1;
        end
      end
      S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  // Sequencer, architectural registers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      pc        <= '0;
      dp        <= '0;
      depth     <= '0;
      res_valid <= 1'b0;
    end else begin
      // result register: load a finished word, or free it once taken
      if (res_load) begin
        res       <= done ? done_res : pend;
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      // finished item: back to idle, or park the word until the register frees
      if (done) begin
        if (out_free) begin
          state <= S_IDLE;
        end else begin
          pend  <= done_res;
          state <= S_RESP;
        end
      end
      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == CW'(MAXD - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_acc && (cmd.func == FUNC_EXEC)) begin
            in_hold <= cmd.in_byte;
            state   <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (prog_rd)
            CH_NUL: begin
            end
            CH_OPEN: begin
              if (data_rd != 8'd0) begin
                pc <= pc_inc;
              end else if (pc != PC_LAST) begin
                scan  <= pc + 1'b1;
                depth <= (PAW + 1)'(1);
                state <= S_SCAN_F;
              end
            end
            CH_CLOSE: begin
              if (pc != '0) begin
                scan  <= pc - 1'b1;
                depth <= (PAW + 1)'(1);
                state <= S_SCAN_B;
              end
            end
            CH_RIGHT: begin
              dp <= dp_inc;
              pc <= pc_inc;
            end
            CH_LEFT: begin
              dp <= dp_dec;
              pc <= pc_inc;
            end
            default: begin
              pc <= pc_inc;
            end
          endcase
        end
        S_SCAN_F: begin
          if (scan_hit) begin
            pc <= scan_inc;
          end else if (!done) begin
            scan <= scan + 1'b1;
            if (prog_rd == CH_CLOSE) begin
              depth <= depth - 1'b1;
            end else if (prog_rd == CH_OPEN) begin
              depth <= depth + 1'b1;
            end
          end
        end
        S_SCAN_B: begin
          if (scan_hit) begin
            pc <= scan;
          end else if (!done) begin
            scan <= scan - 1'b1;
            if (prog_rd == CH_CLOSE) begin
              depth <= depth + 1'b1;
            end else if (prog_rd == CH_OPEN) begin
              depth <= depth - 1'b1;
            end
          end
        end
        S_RESP: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks
  `BFI_ASSERT_NXT(a_scan_pc_hold, clk, rst, ((state == S_SCAN_F) || (state == S_SCAN_B)) && !done, $stable(pc), "pc moved during bracket scan")
  `BFI_ASSERT_IMP(a_data_wr_state, clk, rst, data_we, (state == S_CLEAR) || (state == S_EXEC), "data store written outside clear or execute")
  `BFI_ASSERT_IMP(a_scan_depth, clk, rst, (state == S_SCAN_F) || (state == S_SCAN_B), depth != '0, "bracket depth reached zero while scanning")
  `BFI_ASSERT_IMP(a_halt_alone, clk, rst, res_valid && res.halted, !res.out_valid && !res.in_taken && !res.bracket_error, "halt word carries other flags")

endmodule

`default_nettype wire

// ----- tb/brainfuck_interpreter_core_tb.sv -----
// Self-checking testbench for the Brainfuck interpreter core.
`timescale 1ns / 100ps

module brainfuck_interpreter_core_tb;
  import bfi_pkg::*;

  localparam int PROG_DEPTH = PROG_DEPTH_DEF;
  localparam int DATA_DEPTH = DATA_DEPTH_DEF;
  localparam int DPTR_W     = $clog2(DATA_DEPTH);
  localparam int LIVE       = 0;  // interpreter copy advanced as the DUT accepts words
  localparam int PLAN       = 1;  // interpreter copy advanced as stimulus is built
  localparam int MAX_SHOWN  = 10;
  localparam int PHASE_ITEMS = 180;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd       = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;

  // Two copies of the interpreter state
  logic [7:0]             prog_mem [2][PROG_DEPTH];
  logic [7:0]             data_mem [2][DATA_DEPTH];
  logic [PROG_ADDR_W-1:0] prog_ctr [2];
  logic [DPTR_W-1:0]      data_ptr [2];

  cmd_t cmd_backlog [$];
  res_t res_due [$];
  int   issued       = 0;
  int   checked      = 0;
  int   failures     = 0;
  int   send_gap_pct = 0;
  int   stall_pct    = 0;

  brainfuck_interpreter_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  initial forever #10 clk = ~clk;

  // One interpreter step on copy m; returns the result word it yields
  function automatic res_t interpret(int m, cmd_t c);
    res_t       r;
    logic [7:0] ch;
    logic [7:0] cur;
    int         j;
    int         depth;
    bit         found;
    r = '0;
    if (c.func == FUNC_WRITE) begin
      prog_mem[m][c.prog_addr] = c.prog_char;
      return r;
    end
    ch    = prog_mem[m][prog_ctr[m]];
    cur   = data_mem[m][data_ptr[m]];
    depth = 1;
    found = 1'b0;
    if (ch == CH_NUL) begin
      r.halted = 1'b1;
    end else if (ch == CH_OPEN && cur == 8'h00) begin
      // forward scan; a zero character or the store end means no match
      for (j = prog_ctr[m] + 1; j < PROG_DEPTH; j++) begin
        if (prog_mem[m][j] == CH_NUL) break;
        if (prog_mem[m][j] == CH_CLOSE) depth--;
        if (prog_mem[m][j] == CH_OPEN) depth++;
        if (depth == 0) begin
          found = 1'b1;
          break;
        end
      end
      if (found) prog_ctr[m] = PROG_ADDR_W'(j + 1);
      else r.bracket_error = 1'b1;
    end else if (ch == CH_CLOSE) begin
      // backward scan down to address 0
      j = int'(prog_ctr[m]);
      while (j > 0 && !found) begin
        j--;
        if (prog_mem[m][j] == CH_CLOSE) depth++;
        if (prog_mem[m][j] == CH_OPEN) depth--;
        if (depth == 0) found = 1'b1;
      end
      if (found) prog_ctr[m] = PROG_ADDR_W'(j);
      else r.bracket_error = 1'b1;
    end else begin
      case (ch)
        CH_RIGHT: data_ptr[m] = data_ptr[m] + 1'b1;
        CH_LEFT:  data_ptr[m] = data_ptr[m] - 1'b1;
        CH_INC:   data_mem[m][data_ptr[m]] = cur + 8'd1;
        CH_DEC:   data_mem[m][data_ptr[m]] = cur - 8'd1;
        CH_OUT: begin
          r.out_valid = 1'b1;
          r.out_byte  = cur;
        end
        CH_IN: begin
          data_mem[m][data_ptr[m]] = c.in_byte;
          r.in_taken = 1'b1;
        end
        default: ;
      endcase
      prog_ctr[m] = prog_ctr[m] + 1'b1;
    end
    return r;
  endfunction

  // Any nonzero character that is not an instruction
  function automatic logic [7:0] filler_char();
    logic [7:0] ch;
    do ch = 8'($urandom_range(1, 255));
    while (ch == CH_RIGHT || ch == CH_LEFT || ch == CH_INC || ch == CH_DEC ||
           ch == CH_OUT || ch == CH_IN || ch == CH_OPEN || ch == CH_CLOSE);
    return ch;
  endfunction

  function automatic logic [7:0] pick_op();
    case ($urandom_range(0, 10))
      0:       return CH_RIGHT;
      1:       return CH_LEFT;
      2, 3:    return CH_INC;
      4:       return CH_DEC;
      5:       return CH_OUT;
      6:       return CH_IN;
      7:       return CH_OPEN;
      8:       return CH_CLOSE;
      default: return filler_char();
    endcase
  endfunction

  // Queue a program write; the plan copy follows it
  task automatic put_char(input int addr, input int ch);
    cmd_t c;
    c.func      = FUNC_WRITE;
    c.prog_addr = addr[PROG_ADDR_W-1:0];
    c.prog_char = ch[7:0];
    c.in_byte   = 8'($urandom_range(0, 255));
    cmd_backlog.push_back(c);
    void'(interpret(PLAN, c));
    issued++;
  endtask

  // Queue one instruction step
  task automatic step_prog(input int inb);
    cmd_t c;
    c.func      = FUNC_EXEC;
    c.prog_addr = PROG_ADDR_W'($urandom_range(0, PROG_DEPTH - 1));
    c.prog_char = 8'($urandom_range(0, 255));
    c.in_byte   = inb[7:0];
    cmd_backlog.push_back(c);
    void'(interpret(PLAN, c));
    issued++;
  endtask

  // Short program laid down at the current counter, then run for a while.
  // Most are bracket-balanced; some are random junk with stray brackets.
  task automatic random_program();
    int         base;
    int         len;
    int         depth;
    int         n;
    int         i;
    bit         broken;
    logic [7:0] ch;
    base   = prog_ctr[PLAN];
    len    = $urandom_range(2, 16);
    broken = ($urandom_range(0, 99) < 15);
    depth  = 0;
    for (i = 0; i < len; i++) begin
      if (broken && $urandom_range(0, 1) == 1) ch = 8'($urandom_range(1, 255));
      else ch = pick_op();
      if (!broken) begin
        if (ch == CH_CLOSE) begin
          if (depth == 0) ch = CH_INC;
          else depth--;
        end else if (ch == CH_OPEN) begin
          depth++;
        end
      end
      put_char(base + i, ch);
    end
    for (i = 0; i < depth; i++) put_char(base + len + i, CH_CLOSE);
    put_char(base + len + depth, CH_NUL);
    // stray write anywhere in the store
    if ($urandom_range(0, 9) == 0)
      put_char($urandom_range(0, PROG_DEPTH - 1), $urandom_range(0, 255));
    n = $urandom_range(len, 3 * len + 6);
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 2) == 0) step_prog(0);
      else step_prog($urandom_range(0, 255));
    end
  endtask

  // Wait until every queued word has produced its result
  task automatic settle();
    while (checked < issued) @(posedge clk);
  endtask

  // Command driver; the live copy predicts each accepted word
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && !cmd_stall) res_due.push_back(interpret(LIVE, cmd));
      if (!cmd_valid || !cmd_stall) begin
        if (cmd_backlog.size() > 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          cmd       <= cmd_backlog.pop_front();
          cmd_valid <= 1'b1;
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin : monitor
    res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (res_due.size() == 0) begin
        failures++;
        if (failures <= MAX_SHOWN)
          $display("unexpected result word: ov=%0b ob=%02h it=%0b hl=%0b be=%0b",
                   res.out_valid, res.out_byte, res.in_taken, res.halted,
                   res.bracket_error);
      end else begin
        want = res_due.pop_front();
        checked++;
        if (res.out_valid !== want.out_valid || res.out_byte !== want.out_byte ||
            res.in_taken !== want.in_taken || res.halted !== want.halted ||
            res.bracket_error !== want.bracket_error) begin
          failures++;
          if (failures <= MAX_SHOWN)
            $display("mismatch on word %0d: want ov=%0b ob=%02h it=%0b hl=%0b be=%0b",
                     checked, want.out_valid, want.out_byte, want.in_taken,
                     want.halted, want.bracket_error);
          if (failures <= MAX_SHOWN)
            $display("                     got ov=%0b ob=%02h it=%0b hl=%0b be=%0b",
                     res.out_valid, res.out_byte, res.in_taken, res.halted,
                     res.bracket_error);
        end
      end
    end
    res_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Stimulus, phase by phase
  initial begin : stimulus
    int gap_tbl [4];
    int stall_tbl [4];
    int ph;
    int first;
    int a;
    gap_tbl   = '{0, 62, 0, 35};
    stall_tbl = '{0, 0, 62, 35};
    for (int m = 0; m < 2; m++) begin
      for (a = 0; a < PROG_DEPTH; a++) prog_mem[m][a] = 8'h00;
      for (a = 0; a < DATA_DEPTH; a++) data_mem[m][a] = 8'h00;
      prog_ctr[m] = '0;
      data_ptr[m] = '0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: halt on the empty store, then every instruction and both
    // kinds of unmatched bracket
    step_prog($urandom_range(0, 255));
    put_char(PROG_DEPTH - 1, 8'hFF);
    put_char(0, CH_LEFT);     // pointer wraps down
    put_char(1, CH_DEC);      // cell wraps to FF
    put_char(2, CH_OUT);
    put_char(3, CH_INC);      // cell wraps to 00
    put_char(4, CH_RIGHT);    // pointer wraps up
    put_char(5, CH_IN);
    put_char(6, CH_OPEN);
    put_char(7, CH_CLOSE);
    put_char(8, CH_CLOSE);
    repeat (5) step_prog($urandom_range(0, 255));
    step_prog(0);             // zero the cell for the skip
    step_prog($urandom_range(0, 255));   // skip forward over the pair
    step_prog($urandom_range(0, 255));   // lone close: no match back to 0
    put_char(7, filler_char());
    repeat (3) step_prog($urandom_range(0, 255));  // jump back, skip, halt
    put_char(9, CH_OPEN);
    step_prog($urandom_range(0, 255));   // open with nothing after it
    settle();

    // Random programs under each idling pattern
    for (ph = 0; ph < 4; ph++) begin
      send_gap_pct = gap_tbl[ph];
      stall_pct    = stall_tbl[ph];
      first        = issued;
      while (issued - first < PHASE_ITEMS) random_program();
      settle();
    end

    repeat (40) @(posedge clk);
    failures += res_due.size();
    if (failures == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // Run limit
  initial begin : watchdog
    #500_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/bfi_pkg.sv
sv/brainfuck_interpreter_core.sv
tb/brainfuck_interpreter_core_tb.sv
